[rtl/prbs16_pkg.sv]
// Types, codes and LFSR step functions shared by the PRBS16 generator/checker.
`default_nettype none
package prbs16_pkg;

   localparam logic [1:0] OP_RESTART  = 2'd0;
   localparam logic [1:0] OP_GENERATE = 2'd1;
   localparam logic [1:0] OP_FOLLOW   = 2'd2;

   localparam logic [1:0] GEN_BIT   = 2'd0;
   localparam logic [1:0] GEN_BYTE  = 2'd1;
   localparam logic [1:0] GEN_WORD  = 2'd2;
   localparam logic [1:0] GEN_DWORD = 2'd3;

   localparam logic [4:0] RESYNC_WORD = 5'd16;
   localparam logic [4:0] RESYNC_BYTE = 5'd8;

   localparam logic [15:0] START_RESET = 16'h0001;

   typedef struct packed {
      logic [15:0] shift_reg;
      logic [31:0] fault_count;
      logic [4:0]  resync_bits;
   } state_type;

   typedef struct packed {
      logic [31:0] gen_value;
      logic        mismatch;
      logic [31:0] error_total;
   } result_type;

   function automatic logic [15:0] lfsr_step(input logic [15:0] value);
      logic fb;
      fb = value[0] ^ value[2] ^ value[3] ^ value[5];
      return {fb, value[15:1]};
   endfunction

   function automatic logic [15:0] lfsr_advance8(input logic [15:0] value);
      logic [15:0] acc;
      acc = value;
      for (int i = 0; i < 8; i++) begin
         acc = lfsr_step(acc);
      end
      return acc;
   endfunction

endpackage
`default_nettype wire

[rtl/prbs16_next.sv]
// Next-state and result logic for one PRBS16 request.
`default_nettype none
module prbs16_next (
   input  wire prbs16_pkg::state_type   state,
   input  wire logic [15:0]             start_value,
   input  wire logic [1:0]              op,
   input  wire logic [1:0]              gen_width,
   input  wire logic [7:0]              rx_byte,
   output prbs16_pkg::state_type        state_next,
   output prbs16_pkg::result_type       result
);

   logic [15:0] guarded;
   logic [15:0] adv1;
   logic [15:0] adv8;
   logic [15:0] adv16;
   logic [15:0] adv24;
   logic [15:0] adv32;
   logic [31:0] count_next;

   assign guarded = (state.shift_reg == 16'd0) ? 16'd1 : state.shift_reg;
   assign adv1    = prbs16_pkg::lfsr_step(guarded);
   assign adv8    = prbs16_pkg::lfsr_advance8(guarded);
   assign adv16   = prbs16_pkg::lfsr_advance8(adv8);
   assign adv24   = prbs16_pkg::lfsr_advance8(adv16);
   assign adv32   = prbs16_pkg::lfsr_advance8(adv24);

   always_comb begin
      state_next       = state;
      result.gen_value = 32'd0;
      result.mismatch  = 1'b0;
      count_next       = state.fault_count;
      case (op)
         prbs16_pkg::OP_RESTART: begin
            state_next.shift_reg   = (start_value == 16'd0) ? 16'd1 : start_value;
            state_next.fault_count = 32'd0;
            state_next.resync_bits = prbs16_pkg::RESYNC_WORD;
         end
         prbs16_pkg::OP_GENERATE: begin
            case (gen_width)
               prbs16_pkg::GEN_BIT: begin
                  state_next.shift_reg = adv1;
                  result.gen_value     = {31'd0, adv1[15]};
               end
               prbs16_pkg::GEN_BYTE: begin
                  state_next.shift_reg = adv8;
                  result.gen_value     = {24'd0, adv8[15:8]};
               end
               prbs16_pkg::GEN_WORD: begin
                  state_next.shift_reg = adv16;
                  result.gen_value     = {16'd0, adv16};
               end
               default: begin
                  state_next.shift_reg = adv32;
                  result.gen_value     = {adv16, adv32};
               end
            endcase
         end
         prbs16_pkg::OP_FOLLOW: begin
            if (state.resync_bits != 5'd0) begin
               state_next.shift_reg   = {rx_byte, state.shift_reg[15:8]};
               state_next.resync_bits = (state.resync_bits > prbs16_pkg::RESYNC_BYTE)
                  ? state.resync_bits - prbs16_pkg::RESYNC_BYTE : 5'd0;
            end else if (adv8[15:8] != rx_byte) begin
               state_next.shift_reg   = {rx_byte, 8'd0};
               state_next.resync_bits = prbs16_pkg::RESYNC_BYTE;
               count_next             = state.fault_count + 32'd1;
               state_next.fault_count = count_next;
               result.mismatch        = 1'b1;
            end else begin
               state_next.shift_reg = adv8;
            end
         end
         default: begin
            state_next = state;
         end
      endcase
      result.error_total = (op == prbs16_pkg::OP_RESTART) ? 32'd0 : count_next;
   end

endmodule
`default_nettype wire

[rtl/prbs16_generator_checker.sv]
// Top level of the PRBS16 generator and checker with request/response channels.
`default_nettype none
// One request is accepted per clock cycle when the response slot is free or being
// drained in the same cycle; its response is valid on the following cycle. The whole
// LFSR advance (up to 32 steps) is unrolled XOR logic evaluated in a single pass from
// the state registers to the response register, so the sustained rate is one request
// per cycle while responses drain. start_value is taken at the next restart.
module prbs16_generator_checker (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_write_enable,
   input  wire logic [15:0] csr_write_data,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [1:0]  req_op,
   input  wire logic [1:0]  req_gen_width,
   input  wire logic [7:0]  req_rx_byte,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [31:0]      rsp_gen_value,
   output logic             rsp_mismatch,
   output logic [31:0]      rsp_error_total
);

   logic [15:0]            start_value_ff;
   prbs16_pkg::state_type  state_ff;
   prbs16_pkg::state_type  state_in;
   prbs16_pkg::result_type result_ff;
   prbs16_pkg::result_type result_in;
   logic                   rsp_valid_ff;
   logic                   req_fire;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_fire  = req_valid && req_ready;

   prbs16_next u_next (
      .state       (state_ff),
      .start_value (start_value_ff),
      .op          (req_op),
      .gen_width   (req_gen_width),
      .rx_byte     (req_rx_byte),
      .state_next  (state_in),
      .result      (result_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         start_value_ff       <= prbs16_pkg::START_RESET;
         state_ff.shift_reg   <= prbs16_pkg::START_RESET;
         state_ff.fault_count <= 32'd0;
         state_ff.resync_bits <= prbs16_pkg::RESYNC_WORD;
         rsp_valid_ff         <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            start_value_ff <= csr_write_data;
         end
         if (req_fire) begin
            state_ff     <= state_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         result_ff <= result_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_gen_value   = result_ff.gen_value;
   assign rsp_mismatch    = result_ff.mismatch;
   assign rsp_error_total = result_ff.error_total;

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_mismatch |-> rsp_gen_value == 32'd0)
      else $error("mismatch reported with generated data");

   assert property (@(posedge clock) disable iff (reset)
      req_fire && result_in.mismatch |=>
         state_ff.resync_bits == prbs16_pkg::RESYNC_BYTE
         && state_ff.fault_count == $past(state_ff.fault_count) + 32'd1)
      else $error("mismatch did not arm resync or count the error");

   assert property (@(posedge clock) disable iff (reset)
      req_fire && req_op == prbs16_pkg::OP_RESTART |=>
         state_ff.fault_count == 32'd0
         && state_ff.resync_bits == prbs16_pkg::RESYNC_WORD
         && state_ff.shift_reg != 16'd0)
      else $error("restart left stale state");

   assert property (@(posedge clock) disable iff (reset)
      req_fire && req_op == prbs16_pkg::OP_GENERATE |=> state_ff.shift_reg != 16'd0)
      else $error("generate produced an all-zero register");

   assert property (@(posedge clock) disable iff (reset)
      req_fire |=> rsp_valid && rsp_error_total == state_ff.fault_count)
      else $error("response count out of step with state");

endmodule
`default_nettype wire
